// File: rtl/ccaq_pkg.sv
// shared types, codes and calendar helpers for the alarm queue block
package ccaq_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_ADD    = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;     // capture input transaction
        logic do_tick;     // advance clock and check head
        logic do_set;      // load time
        logic scan_step;   // advance scan index
        logic shift_step;  // move one queue entry
        logic write_new;   // write new alarm at scan index
        logic dec_count;   // drop one entry
        logic inc_count;   // add one entry
        logic set_fail;    // mark result not ok
        logic out_load;    // present result
    } ccaq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       add_reject;  // raw time not later or queue full
        logic       tick_fire;   // ticked time matches the head alarm
        logic       scan_done;   // scan reached target or end
        logic       scan_found;  // scan stopped on a real entry
        logic       shift_done;  // no more entries to move
    } ccaq_sts_t;

    function automatic logic [4:0] month_len(input logic [5:0] yr, input logic [3:0] mo);
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd2: month_len = (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: month_len = 5'd30;
        endcase
    endfunction

    // carry rule on a packed time, second widened before the optional increment;
    // bit 32 flags a month advance
    function automatic logic [32:0] carry_time(input logic [31:0] t, input logic inc);
        logic [5:0] yr;
        logic [3:0] mo;
        logic [5:0] dt;
        logic [5:0] hr;
        logic [6:0] mi;
        logic [6:0] se;
        logic       rolled;
        yr = t[31:26];
        mo = t[25:22];
        dt = {1'b0, t[21:17]};
        hr = {1'b0, t[16:12]};
        mi = {1'b0, t[11:6]};
        se = {1'b0, t[5:0]} + {6'd0, inc};
        rolled = 1'b0;
        if (se >= 7'd60) begin
            se = se - 7'd60;
            mi = mi + 7'd1;
            if (mi >= 7'd60) begin
                mi = mi - 7'd60;
                hr = hr + 6'd1;
                if (hr >= 6'd24) begin
                    hr = hr - 6'd24;
                    dt = dt + 6'd1;
                    if (dt > {1'b0, month_len(yr, mo)}) begin
                        rolled = 1'b1;
                        dt = 6'd1;
                        if (mo >= 4'd12) begin
                            mo = 4'd1;
                            yr = yr + 6'd1;
                        end else begin
                            mo = mo + 4'd1;
                        end
                    end
                end
            end
        end
        carry_time = {rolled, yr, mo, dt[4:0], hr[4:0], mi[5:0], se[5:0]};
    endfunction

endpackage

// File: rtl/ccaq_ctrl.sv
// controller state machine sequencing each operation
module ccaq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  ccaq_pkg::ccaq_sts_t sts,
    output ccaq_pkg::ccaq_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                case (sts.op)
                    ccaq_pkg::OP_TICK: begin
                        cmd.do_tick = 1'b1;
                        // a fired head is popped by walking the queue down
                        state_next = sts.tick_fire ? ST_SHIFT : ST_DONE;
                    end
                    ccaq_pkg::OP_SET: begin
                        cmd.do_set = 1'b1;
                        state_next = ST_DONE;
                    end
                    ccaq_pkg::OP_ADD: begin
                        if (sts.add_reject) begin
                            cmd.set_fail = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    default: state_next = ST_SCAN;
                endcase
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    if (sts.op == ccaq_pkg::OP_REMOVE && !sts.scan_found) begin
                        cmd.set_fail = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SHIFT;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (sts.shift_done) begin
                    if (sts.op == ccaq_pkg::OP_ADD) begin
                        cmd.write_new = 1'b1;
                        cmd.inc_count = 1'b1;
                    end else begin
                        cmd.dec_count = 1'b1;
                    end
                    state_next = ST_DONE;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_one_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.inc_count && cmd.dec_count)) else $error("count grows and shrinks");
    a_tick_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_tick && !sts.tick_fire |=> state_reg == ST_DONE) else $error("tick did not finish");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |-> state_reg == ST_IDLE) else $error("bad load");

endmodule

// File: rtl/ccaq_dp.sv
// datapath: clock registers, alarm queue and result register
module ccaq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [47:0]         s_tdata,
    input  ccaq_pkg::ccaq_cmd_t cmd,
    output ccaq_pkg::ccaq_sts_t sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [39:0]   mem [QUEUE_DEPTH];
    logic [31:0]   now_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] tail_reg;
    logic [CW-1:0] src_pos;
    logic [1:0]    op_reg;
    logic [31:0]   raw_reg;
    logic [7:0]    tag_reg;
    logic          ok_reg, fired_reg, rolled_reg;
    logic [7:0]    ftag_reg;
    logic [39:0]   rd_entry;
    logic [32:0]   tick_c, add_c;
    logic          in_range;
    logic          head_match;

    assign tick_c     = ccaq_pkg::carry_time(now_reg, 1'b1);
    assign add_c      = ccaq_pkg::carry_time(raw_reg, 1'b0);
    assign in_range   = idx_reg < count_reg;
    assign rd_entry   = mem[idx_reg[IW-1:0]];
    assign head_match = (count_reg != '0) && (mem[0][39:8] == tick_c[31:0]);

    // add shifting walks from the tail down to the insert position
    assign src_pos = count_reg - tail_reg - CW'(1);

    // status towards the controller
    always_comb begin
        sts.op = op_reg;
        sts.add_reject = (raw_reg <= now_reg) || (count_reg == CW'(QUEUE_DEPTH));
        sts.tick_fire = head_match;
        if (op_reg == ccaq_pkg::OP_ADD) begin
            sts.scan_done = !in_range || !(rd_entry[39:8] < add_c[31:0]);
        end else begin
            sts.scan_done = !in_range || rd_entry[7:0] == tag_reg;
        end
        sts.scan_found = in_range;
        if (op_reg == ccaq_pkg::OP_ADD) begin
            sts.shift_done = (count_reg - tail_reg) == idx_reg;
        end else begin
            sts.shift_done = idx_reg + CW'(1) >= count_reg;
        end
    end

    // captured transaction, scan index and tail pointer for add shifting
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_tdata[1:0];
            raw_reg <= s_tdata[33:2];
            tag_reg <= s_tdata[41:34];
            idx_reg <= '0;
            ok_reg  <= 1'b1;
            tail_reg <= '0;
            fired_reg <= 1'b0;
            ftag_reg <= '0;
            rolled_reg <= 1'b0;
        end
        if (cmd.scan_step) idx_reg <= idx_reg + CW'(1);
        if (cmd.set_fail) ok_reg <= 1'b0;
        if (cmd.do_tick) begin
            rolled_reg <= tick_c[32];
            if (head_match) begin
                fired_reg <= 1'b1;
                ftag_reg  <= mem[0][7:0];
            end
        end
        if (cmd.shift_step && op_reg != ccaq_pkg::OP_ADD) idx_reg <= idx_reg + CW'(1);
        if (cmd.shift_step && op_reg == ccaq_pkg::OP_ADD) tail_reg <= tail_reg + CW'(1);
    end

    // queue memory, one entry moved per cycle
    always_ff @(posedge aclk) begin
        if (cmd.shift_step) begin
            if (op_reg == ccaq_pkg::OP_ADD) begin
                mem[IW'(src_pos + CW'(1))] <= mem[src_pos[IW-1:0]];
            end else begin
                mem[idx_reg[IW-1:0]] <= mem[IW'(idx_reg + CW'(1))];
            end
        end else if (cmd.write_new) begin
            mem[idx_reg[IW-1:0]] <= {add_c[31:0], tag_reg};
        end
    end

    // clock and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.do_tick) now_reg <= tick_c[31:0];
            if (cmd.do_set) now_reg <= raw_reg;
            if (cmd.inc_count) count_reg <= count_reg + CW'(1);
            if (cmd.dec_count) count_reg <= count_reg - CW'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata <= {5'd0, now_reg[5:0], now_reg[11:6], now_reg[16:12], now_reg[21:17],
                        now_reg[25:22], now_reg[31:26], rolled_reg, ftag_reg, fired_reg,
                        ok_reg};
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("queue overfilled");
    a_no_inc_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.inc_count |-> count_reg != CW'(QUEUE_DEPTH)) else $error("insert into full queue");
    a_no_dec_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dec_count |-> count_reg != '0) else $error("remove from empty queue");

endmodule

// File: rtl/calendar_clock_alarm_queue_core.sv
// calendar clock with sorted alarm queue, top level
// path from input transaction to m_tvalid: tick, set and rejected add finish after decode;
// add scans then shifts, remove scans and shifts if found, fired tick shifts; one queue entry moved per cycle
// throughput: one transaction at a time, next input accepted in the cycle m_tvalid rises
// reset: synchronous active-low aresetn clears time, count and handshake; queue left undefined
module calendar_clock_alarm_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation, in_year, in_month, in_date, in_hour, in_minute, in_second, alarm_tag
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok, fired, fired_tag, month_rolled, now_year, now_month, now_date, now_hour,
    // now_minute, now_second
    output logic [47:0] m_tdata
);

    ccaq_pkg::ccaq_cmd_t cmd;
    ccaq_pkg::ccaq_sts_t sts;
    logic [47:0] din;

    // repack time so packed order is calendar order
    assign din = {6'd0, s_tdata[41:34], s_tdata[7:2], s_tdata[11:8], s_tdata[16:12],
                  s_tdata[21:17], s_tdata[27:22], s_tdata[33:28], s_tdata[1:0]};

    ccaq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
    );

    ccaq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(din), .cmd(cmd), .sts(sts),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

// File: tb/tb.sv
// testbench for the calendar clock and alarm queue: random driver, predictor and result check
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // predicts each result from its own copy of the clock and the alarm list
    class alarm_scoreboard;
        logic [31:0] now_time;
        logic [39:0] alarm_list[$];
        logic [47:0] expected_results[$];
        int          errors;
        int          fired_count;
        int          rolled_count;
        int          rejects;
        int          depth;

        function new(int qdepth);
            depth = qdepth;
            now_time = '0;
            errors = 0;
            fired_count = 0;
            rolled_count = 0;
            rejects = 0;
        endfunction

        function int days_in(int yr, int mo);
            if (mo == 1 || mo == 3 || mo == 5 || mo == 7 || mo == 8 || mo == 10 || mo == 12)
                return 31;
            if (mo == 2)
                return (yr % 4 == 0) ? 29 : 28;
            return 30;
        endfunction

        // one carry pass over wide fields, second bumped first; bit 32 says the month moved on
        function logic [32:0] normalise(logic [31:0] t, int inc);
            int yr, mo, dt, hr, mi, se;
            logic rolled;
            yr = t[31:26]; mo = t[25:22]; dt = t[21:17];
            hr = t[16:12]; mi = t[11:6];  se = t[5:0];
            se += inc;
            rolled = 1'b0;
            if (se >= 60) begin
                se -= 60; mi += 1;
                if (mi >= 60) begin
                    mi -= 60; hr += 1;
                    if (hr >= 24) begin
                        hr -= 24; dt += 1;
                        if (dt > days_in(yr, mo)) begin
                            rolled = 1'b1;
                            dt = 1;
                            if (mo >= 12) begin
                                mo = 1;
                                yr = (yr + 1) % 64;
                            end else begin
                                mo += 1;
                            end
                        end
                    end
                end
            end
            return {rolled, yr[5:0], mo[3:0], dt[4:0], hr[4:0], mi[5:0], se[5:0]};
        endfunction

        function void note_input(logic [47:0] d);
            logic [1:0]  op;
            logic [31:0] raw;
            logic [32:0] c;
            logic [7:0]  tag;
            logic        ok, fired, rolled;
            logic [7:0]  ftag;
            int          pos;
            op  = d[1:0];
            raw = {d[7:2], d[11:8], d[16:12], d[21:17], d[27:22], d[33:28]};
            tag = d[41:34];
            ok = 1'b1; fired = 1'b0; rolled = 1'b0; ftag = '0;
            case (op)
                ccaq_pkg::OP_TICK: begin
                    c = normalise(now_time, 1);
                    rolled = c[32];
                    now_time = c[31:0];
                    if (alarm_list.size() > 0 && alarm_list[0][39:8] == now_time) begin
                        fired = 1'b1;
                        ftag = alarm_list[0][7:0];
                        void'(alarm_list.pop_front());
                    end
                end
                ccaq_pkg::OP_SET: now_time = raw;
                ccaq_pkg::OP_ADD: begin
                    if (raw <= now_time || alarm_list.size() >= depth) begin
                        ok = 1'b0;
                    end else begin
                        c = normalise(raw, 0);
                        pos = 0;
                        while (pos < alarm_list.size() && alarm_list[pos][39:8] < c[31:0])
                            pos++;
                        alarm_list.insert(pos, {c[31:0], tag});
                    end
                end
                default: begin
                    pos = 0;
                    while (pos < alarm_list.size() && alarm_list[pos][7:0] != tag)
                        pos++;
                    if (pos >= alarm_list.size())
                        ok = 1'b0;
                    else
                        alarm_list.delete(pos);
                end
            endcase
            if (!ok) rejects++;
            if (fired) fired_count++;
            if (rolled) rolled_count++;
            expected_results.push_back({5'd0, now_time[5:0], now_time[11:6], now_time[16:12],
                now_time[21:17], now_time[25:22], now_time[31:26], rolled, ftag, fired, ok});
        endfunction

        function void cmp(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [47:0] r);
            logic [47:0] e;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: %h", r);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            cmp("ok", e[0], r[0]);
            cmp("fired", e[1], r[1]);
            cmp("fired_tag", e[9:2], r[9:2]);
            cmp("month_rolled", e[10], r[10]);
            cmp("now_year", e[16:11], r[16:11]);
            cmp("now_month", e[20:17], r[20:17]);
            cmp("now_date", e[25:21], r[25:21]);
            cmp("now_hour", e[30:26], r[30:26]);
            cmp("now_minute", e[36:31], r[36:31]);
            cmp("now_second", e[42:37], r[42:37]);
            cmp("padding", e[47:43], r[47:43]);
        endfunction
    endclass

    localparam int DEPTH = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    alarm_scoreboard sb = new(DEPTH);
    bit hold_off_req = 1'b0;
    int sent = 0;

    calendar_clock_alarm_queue_core #(.QUEUE_DEPTH(DEPTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // watch both channels for completed transactions
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                hold_off_req = 1'b0;
                for (n = 0; n < 400; n++) @(posedge aclk);
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 30) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [47:0] pack_item(logic [1:0] op, logic [31:0] t, logic [7:0] tag);
        return {6'd0, tag, t[5:0], t[11:6], t[16:12], t[21:17], t[25:22], t[31:26], op};
    endfunction

    function automatic logic [31:0] mk_time(int yr, int mo, int dt, int hr, int mi, int se);
        return {yr[5:0], mo[3:0], dt[4:0], hr[4:0], mi[5:0], se[5:0]};
    endfunction

    // one transaction, sometimes followed by a random gap between bursts
    task automatic send(logic [47:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if ($urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (2 * DEPTH + 8) @(posedge aclk);
    endtask

    // alarm up to six seconds past now, second field left raw for the carry
    function automatic logic [31:0] near_future(logic [31:0] now);
        int se;
        se = now[5:0] + $urandom_range(0, 6);
        if (se > 63) se = 63;
        return {now[31:6], 6'(se)};
    endfunction

    task automatic random_item();
        int sel;
        logic [31:0] t;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            send(pack_item(ccaq_pkg::OP_TICK, $urandom, 8'($urandom)));
        end else if (sel < 72) begin
            send(pack_item(ccaq_pkg::OP_ADD, near_future(sb.now_time),
                8'($urandom_range(0, 15))));
        end else if (sel < 82) begin
            send(pack_item(ccaq_pkg::OP_REMOVE, $urandom, 8'($urandom_range(0, 15))));
        end else if (sel < 90) begin
            // just before a rollover of minute, day, month or year
            t = mk_time($urandom_range(0, 63), $urandom_range(1, 12), 28, 23, 59,
                $urandom_range(50, 59));
            t[21:17] = 5'(sb.days_in(t[31:26], t[25:22]) - int'($urandom_range(0, 1)));
            send(pack_item(ccaq_pkg::OP_SET, t, 8'($urandom)));
        end else begin
            // noise over the full field ranges
            send({6'd0, 42'($urandom) | (42'($urandom) << 32)});
        end
    endtask

    initial begin : stimulus
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every operation, rollovers, rejects and a full queue
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        send(pack_item(ccaq_pkg::OP_REMOVE, '0, 8'hff));
        send(pack_item(ccaq_pkg::OP_SET, mk_time(63, 15, 31, 31, 63, 63), 8'hff));
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        send(pack_item(ccaq_pkg::OP_SET, mk_time(63, 12, 31, 23, 59, 59), '0));
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        send(pack_item(ccaq_pkg::OP_SET, mk_time(4, 2, 28, 23, 59, 59), '0));
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        send(pack_item(ccaq_pkg::OP_SET, mk_time(5, 2, 28, 23, 59, 59), '0));
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        send(pack_item(ccaq_pkg::OP_ADD, mk_time(5, 3, 1, 0, 0, 0), 8'd1));
        send(pack_item(ccaq_pkg::OP_ADD, mk_time(5, 3, 1, 0, 0, 2), 8'd2));
        send(pack_item(ccaq_pkg::OP_ADD, mk_time(5, 3, 1, 0, 0, 63), 8'd3));
        send(pack_item(ccaq_pkg::OP_ADD, mk_time(5, 3, 1, 0, 0, 2), 8'hff));
        send(pack_item(ccaq_pkg::OP_REMOVE, '0, 8'd3));
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        send(pack_item(ccaq_pkg::OP_REMOVE, '0, 8'd1));
        send(pack_item(ccaq_pkg::OP_TICK, '0, '0));
        for (i = 0; i < DEPTH + 1; i++)
            send(pack_item(ccaq_pkg::OP_ADD, mk_time(6, 1, 1, 0, 0, i % 5), 8'(i)));
        wait_drained();

        // random part with one long receiver stall and one full drain
        for (i = 0; i < 400; i++) begin
            if (i == 120) hold_off_req = 1'b1;
            if (i == 250) wait_drained();
            random_item();
        end
        wait_drained();

        $display("covered %0d transactions: %0d alarms fired, %0d month rollovers, %0d rejected",
            sent, sb.fired_count, sb.rolled_count, sb.rejects);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // overall limit
    initial begin : watchdog
        #20_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
